FILE: hw/rtl/shared_buffer_threshold_control_top_macros.svh
// ---------------------------------------------------------------------------
// Shared buffer threshold control assertion macros
// Short forms for the clocked assertions used in the RTL.
// ---------------------------------------------------------------------------
`ifndef SHARED_BUFFER_THRESHOLD_CONTROL_TOP_MACROS_SVH
`define SHARED_BUFFER_THRESHOLD_CONTROL_TOP_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define SBTC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: whenever the trigger holds, the consequence holds.
`define SBTC_ASSERT_IMPL(name, clk, rst_n, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sbtc_pkg.sv
// ---------------------------------------------------------------------------
// Shared buffer threshold control package
// Types, constants and helpers shared by the front, back and top level.
// ---------------------------------------------------------------------------
package sbtc_pkg;

  localparam int unsigned NumPorts = 16;
  localparam int unsigned PortBits = 4;
  localparam int unsigned LenBits  = 16;
  localparam int unsigned SumBits  = 20;
  localparam int unsigned CntBits  = 5;
  localparam logic [7:0]  RunMax   = 8'd255;
  localparam logic [SumBits-1:0] SumLimit = 20'd1048560;

  // Event opcodes.
  localparam logic [1:0] OpQueue = 2'd0;
  localparam logic [1:0] OpDrop  = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  // Sharing modes.
  localparam logic [1:0] ModeComplete = 2'd0;
  localparam logic [1:0] ModeStatic   = 2'd1;
  localparam logic [1:0] ModeDynamic  = 2'd2;
  localparam logic [1:0] ModeEnhanced = 2'd3;

  // Register indexes.
  typedef enum logic [2:0] {
    RegMode    = 3'd0,
    RegBuffer  = 3'd1,
    RegAlpha   = 3'd2,
    RegDqLimit = 3'd3,
    RegEqLimit = 3'd4,
    RegHold    = 3'd5,
    RegRelease = 3'd6,
    RegNone    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    KindQueue,
    KindDrop,
    KindTick,
    KindNone
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StTick,
    StMul,
    StThresh,
    StDiv,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  port;
    logic [15:0] new_length;
  } item_t;

  typedef struct packed {
    logic [15:0] shared_threshold;
    logic [15:0] boosted_threshold;
    logic [15:0] uncontrolled_mask;
    logic [4:0]  uncontrolled_count;
    logic [19:0] total_use;
  } result_t;

  typedef struct packed {
    kind_e               kind;
    logic [PortBits-1:0] port;
    logic [LenBits-1:0]  len;
  } job_t;

  typedef struct packed {
    logic [1:0]  sharing_mode;
    logic [15:0] total_buffer;
    logic [11:0] alpha_q8;
    logic [7:0]  dequeue_run_limit;
    logic [7:0]  enqueue_run_limit;
    logic [15:0] hold_ticks;
    logic [15:0] release_ticks;
  } cfg_t;

  // Number of set bits in the uncontrolled vector.
  function automatic logic [CntBits-1:0] popcount(input logic [NumPorts-1:0] v);
    logic [CntBits-1:0] n;
    n = '0;
    for (int i = 0; i < NumPorts; i++) begin
      n = n + CntBits'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/sbtc_front.sv
// ---------------------------------------------------------------------------
// Shared buffer threshold control front end
// Accepts event words, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module sbtc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sbtc_pkg::item_t item_i,
  output logic            busy_o,
  output logic            job_valid_o,
  output sbtc_pkg::job_t  job_o,
  input  logic            job_pop_i
);

  sbtc_pkg::job_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  sbtc_pkg::job_t job_in;
  logic           push;

  // Classify the incoming word.
  always_comb begin
    job_in.port = item_i.port;
    job_in.len  = item_i.new_length;
    case (item_i.opcode)
      sbtc_pkg::OpQueue: job_in.kind = sbtc_pkg::KindQueue;
      sbtc_pkg::OpDrop:  job_in.kind = sbtc_pkg::KindDrop;
      sbtc_pkg::OpTick:  job_in.kind = sbtc_pkg::KindTick;
      default:           job_in.kind = sbtc_pkg::KindNone;
    endcase
  end

  assign busy_o      = (count_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign job_valid_o = (count_q != 2'd0);
  assign job_o       = fifo_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ (job_pop_i && job_valid_o);
    count_d  = count_q + 2'(push) - 2'(job_pop_i && job_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

FILE: hw/rtl/sbtc_back.sv
// ---------------------------------------------------------------------------
// Shared buffer threshold control back end
// Holds per-port state, runs queue, drop and tick events, and computes
// the shared and boosted thresholds, using a serial divider for the boosted one in enhanced mode.
// ---------------------------------------------------------------------------
`include "shared_buffer_threshold_control_top_macros.svh"

module sbtc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbtc_pkg::cfg_t    cfg_i,
  input  logic              job_valid_i,
  input  sbtc_pkg::job_t    job_i,
  output logic              job_pop_o,
  output logic              result_valid_o,
  output sbtc_pkg::result_t result_o
);

  typedef struct packed {
    logic pop;
    logic port_wr;
    logic step_idx;
  } ctrl_t;

  sbtc_pkg::state_e state_q, state_d;
  ctrl_t            ctrl;

  // Per-port state.
  logic [15:0] ql_q [sbtc_pkg::NumPorts];
  logic [7:0]  dq_q [sbtc_pkg::NumPorts];
  logic [7:0]  eq_q [sbtc_pkg::NumPorts];
  logic [15:0] ht_q [sbtc_pkg::NumPorts];
  logic [15:0] rt_q [sbtc_pkg::NumPorts];
  logic [sbtc_pkg::NumPorts-1:0] boost_q, unc_q, started_q, rr_q;

  sbtc_pkg::job_t                 job_q;
  logic [sbtc_pkg::PortBits-1:0]  idx_q;
  logic [sbtc_pkg::SumBits-1:0]   total_q;
  logic [15:0]                    shared_q, boosted_q;
  logic [27:0]                    prod_q;
  logic                           over_q;
  logic [15:0]                    dvd_q;
  logic [4:0]                     rem_q;
  logic [3:0]                     dcnt_q;
  logic                           result_valid_q;
  sbtc_pkg::result_t              result_q;

  // New values for the addressed port.
  logic [15:0] n_ql, n_ht, n_rt;
  logic [7:0]  n_dq, n_eq;
  logic        n_boost, n_unc, n_started, n_rr;
  logic [sbtc_pkg::CntBits-1:0] unc_cnt;

  assign unc_cnt = sbtc_pkg::popcount(unc_q);

  // Port update for queue, drop and tick events.
  always_comb begin
    n_ql      = ql_q[idx_q];
    n_dq      = dq_q[idx_q];
    n_eq      = eq_q[idx_q];
    n_ht      = ht_q[idx_q];
    n_rt      = rt_q[idx_q];
    n_boost   = boost_q[idx_q];
    n_unc     = unc_q[idx_q];
    n_started = started_q[idx_q];
    n_rr      = rr_q[idx_q];
    if (state_q == sbtc_pkg::StExec && job_q.kind == sbtc_pkg::KindQueue) begin
      if (!n_started) begin
        n_started = 1'b1;
        n_ht      = cfg_i.hold_ticks;
      end
      if (n_ql > job_q.len) begin
        if (n_dq != sbtc_pkg::RunMax) n_dq = n_dq + 8'd1;
        if (n_eq != 8'd0) n_eq = n_eq - 8'd1;
        if (n_dq == cfg_i.dequeue_run_limit) begin
          n_eq    = 8'd0;
          n_unc   = 1'b0;
          n_boost = 1'b0;
          n_rr    = 1'b0;
        end
      end else begin
        n_dq = 8'd0;
        if (n_eq != sbtc_pkg::RunMax) n_eq = n_eq + 8'd1;
        if (n_eq == cfg_i.enqueue_run_limit) begin
          n_unc   = 1'b1;
          n_boost = 1'b1;
          n_rt    = cfg_i.release_ticks;
          n_rr    = 1'b1;
        end
      end
      if (!n_boost) begin
        n_dq = 8'd0;
      end else begin
        n_eq = 8'd0;
        n_ht = cfg_i.hold_ticks;
      end
      n_ql = job_q.len;
    end else if (state_q == sbtc_pkg::StExec) begin
      // Drop event.
      n_unc = 1'b0;
      n_rr  = 1'b0;
      n_eq  = 8'd0;
    end else begin
      // Tick walk: hold timer first, release wins.
      if (n_started) begin
        if (n_ht <= 16'd1) begin
          n_eq    = 8'd0;
          n_boost = 1'b1;
          n_ht    = cfg_i.hold_ticks;
        end else begin
          n_ht = n_ht - 16'd1;
        end
      end
      if (n_rr) begin
        if (n_rt <= 16'd1) begin
          n_unc   = 1'b0;
          n_boost = 1'b0;
          n_rr    = 1'b0;
        end else begin
          n_rt = n_rt - 16'd1;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbtc_pkg::StIdle: begin
        if (job_valid_i) begin
          case (job_i.kind)
            sbtc_pkg::KindQueue, sbtc_pkg::KindDrop: state_d = sbtc_pkg::StExec;
            sbtc_pkg::KindTick: state_d = sbtc_pkg::StTick;
            default: state_d = sbtc_pkg::StDone;
          endcase
        end
      end
      sbtc_pkg::StExec: begin
        state_d = (job_q.kind == sbtc_pkg::KindQueue) ? sbtc_pkg::StMul : sbtc_pkg::StDone;
      end
      sbtc_pkg::StTick: begin
        if (idx_q == sbtc_pkg::PortBits'(sbtc_pkg::NumPorts - 1)) state_d = sbtc_pkg::StDone;
      end
      sbtc_pkg::StMul: state_d = sbtc_pkg::StThresh;
      sbtc_pkg::StThresh: begin
        if (cfg_i.sharing_mode == sbtc_pkg::ModeEnhanced && unc_cnt != '0) begin
          state_d = sbtc_pkg::StDiv;
        end else begin
          state_d = sbtc_pkg::StDone;
        end
      end
      sbtc_pkg::StDiv: begin
        if (dcnt_q == 4'd15) state_d = sbtc_pkg::StDone;
      end
      sbtc_pkg::StDone: state_d = sbtc_pkg::StIdle;
      default: state_d = sbtc_pkg::StIdle;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl          = '0;
    ctrl.pop      = (state_q == sbtc_pkg::StIdle) && job_valid_i;
    ctrl.port_wr  = (state_q == sbtc_pkg::StExec) || (state_q == sbtc_pkg::StTick);
    ctrl.step_idx = (state_q == sbtc_pkg::StTick);
  end

  assign job_pop_o = ctrl.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbtc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-port state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbtc_pkg::NumPorts; i++) begin
        ql_q[i] <= '0;
        dq_q[i] <= '0;
        eq_q[i] <= '0;
        ht_q[i] <= '0;
        rt_q[i] <= '0;
      end
      boost_q   <= '0;
      unc_q     <= '0;
      started_q <= '0;
      rr_q      <= '0;
    end else if (ctrl.port_wr) begin
      ql_q[idx_q]      <= n_ql;
      dq_q[idx_q]      <= n_dq;
      eq_q[idx_q]      <= n_eq;
      ht_q[idx_q]      <= n_ht;
      rt_q[idx_q]      <= n_rt;
      boost_q[idx_q]   <= n_boost;
      unc_q[idx_q]     <= n_unc;
      started_q[idx_q] <= n_started;
      rr_q[idx_q]      <= n_rr;
    end
  end

  // Running total, thresholds and result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q        <= '0;
      shared_q       <= '0;
      boosted_q      <= '0;
      idx_q          <= '0;
      dcnt_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= (state_q == sbtc_pkg::StDone);
      if (ctrl.pop) begin
        idx_q <= (job_i.kind == sbtc_pkg::KindTick) ? '0 : job_i.port;
      end else if (ctrl.step_idx) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == sbtc_pkg::StExec && job_q.kind == sbtc_pkg::KindQueue) begin
        total_q <= total_q - sbtc_pkg::SumBits'(ql_q[idx_q]) + sbtc_pkg::SumBits'(job_q.len);
      end
      if (state_q == sbtc_pkg::StThresh) begin
        dcnt_q <= '0;
        case (cfg_i.sharing_mode)
          sbtc_pkg::ModeComplete: shared_q <= cfg_i.total_buffer;
          sbtc_pkg::ModeStatic:   shared_q <= cfg_i.total_buffer >> sbtc_pkg::PortBits;
          default: begin
            if (over_q) shared_q <= 16'd0;
            else if (prod_q[27:24] != 4'd0) shared_q <= 16'hFFFF;
            else shared_q <= prod_q[23:8];
          end
        endcase
      end
      if (state_q == sbtc_pkg::StThresh && state_d == sbtc_pkg::StDone) begin
        case (cfg_i.sharing_mode)
          sbtc_pkg::ModeComplete: boosted_q <= cfg_i.total_buffer;
          sbtc_pkg::ModeStatic:   boosted_q <= cfg_i.total_buffer >> sbtc_pkg::PortBits;
          default: begin
            if (over_q) boosted_q <= 16'd0;
            else if (prod_q[27:24] != 4'd0) boosted_q <= 16'hFFFF;
            else boosted_q <= prod_q[23:8];
          end
        endcase
      end
      if (state_q == sbtc_pkg::StDiv) begin
        dcnt_q <= dcnt_q + 4'd1;
        if (dcnt_q == 4'd15) begin
          boosted_q <= {dvd_q[14:0],
                        ({rem_q, dvd_q[15]} >= {1'b0, unc_cnt})};
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (ctrl.pop) begin
      job_q <= job_i;
    end
    if (state_q == sbtc_pkg::StMul) begin
      over_q <= (sbtc_pkg::SumBits'(cfg_i.total_buffer) <= total_q);
      prod_q <= 28'(cfg_i.alpha_q8) * 28'(cfg_i.total_buffer - total_q[15:0]);
    end
    // Restoring divider: one quotient bit per cycle.
    if (state_q == sbtc_pkg::StThresh) begin
      dvd_q <= cfg_i.total_buffer;
      rem_q <= '0;
    end else if (state_q == sbtc_pkg::StDiv) begin
      if ({rem_q, dvd_q[15]} >= {1'b0, unc_cnt}) begin
        rem_q <= 5'({rem_q, dvd_q[15]} - {1'b0, unc_cnt});
        dvd_q <= {dvd_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[3:0], dvd_q[15]};
        dvd_q <= {dvd_q[14:0], 1'b0};
      end
    end
    if (state_q == sbtc_pkg::StDone) begin
      result_q.shared_threshold   <= shared_q;
      result_q.boosted_threshold  <= boosted_q;
      result_q.uncontrolled_mask  <= unc_q;
      result_q.uncontrolled_count <= unc_cnt;
      result_q.total_use          <= total_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // The strobe lasts one cycle, the divider never sees a zero divisor,
  // queue words are taken only from idle, and the total stays in range.
  `SBTC_ASSERT(a_strobe_single, clk_i, rst_ni, result_valid_q |=> !result_valid_q, "strobe held")
  `SBTC_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == sbtc_pkg::StDiv, unc_cnt != '0, "divide by zero")
  `SBTC_ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, job_pop_o, state_q == sbtc_pkg::StIdle, "pop while busy")
  `SBTC_ASSERT(a_total_range, clk_i, rst_ni, total_q <= sbtc_pkg::SumLimit, "total out of range")

endmodule

FILE: hw/rtl/shared_buffer_threshold_control_top.sv
// ---------------------------------------------------------------------------
// Shared buffer threshold control top level
// Register port, event front end and threshold back end.
// ---------------------------------------------------------------------------
// Each accepted event word produces exactly one result word, strobed by
// result_valid_o for a single cycle; the receiver cannot stall it. For a
// timer tick the back end walks the 16 port timers one per cycle, and a
// queue length change in enhanced mode with uncontrolled ports runs a serial
// divider that produces one quotient bit per cycle. A two-word queue sits in
// front, so busy_o is high only while it is full. Write registers only
// while no event is in flight.
module shared_buffer_threshold_control_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sbtc_pkg::item_t   item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output sbtc_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  sbtc_pkg::cfg_t     cfg_q;
  sbtc_pkg::reg_idx_e reg_idx;
  sbtc_pkg::job_t     job;
  logic               job_valid, job_pop;

  assign pready  = 1'b1;
  assign reg_idx = sbtc_pkg::reg_idx_e'(paddr[4:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sharing_mode      <= 2'd3;
      cfg_q.total_buffer      <= 16'd175;
      cfg_q.alpha_q8          <= 12'd256;
      cfg_q.dequeue_run_limit <= 8'd3;
      cfg_q.enqueue_run_limit <= 8'd8;
      cfg_q.hold_ticks        <= 16'd21;
      cfg_q.release_ticks     <= 16'd100;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        sbtc_pkg::RegMode:    cfg_q.sharing_mode      <= pwdata[1:0];
        sbtc_pkg::RegBuffer:  cfg_q.total_buffer      <= pwdata[15:0];
        sbtc_pkg::RegAlpha:   cfg_q.alpha_q8          <= pwdata[11:0];
        sbtc_pkg::RegDqLimit: cfg_q.dequeue_run_limit <= pwdata[7:0];
        sbtc_pkg::RegEqLimit: cfg_q.enqueue_run_limit <= pwdata[7:0];
        sbtc_pkg::RegHold:    cfg_q.hold_ticks        <= pwdata[15:0];
        sbtc_pkg::RegRelease: cfg_q.release_ticks     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_idx)
      sbtc_pkg::RegMode:    prdata = 32'(cfg_q.sharing_mode);
      sbtc_pkg::RegBuffer:  prdata = 32'(cfg_q.total_buffer);
      sbtc_pkg::RegAlpha:   prdata = 32'(cfg_q.alpha_q8);
      sbtc_pkg::RegDqLimit: prdata = 32'(cfg_q.dequeue_run_limit);
      sbtc_pkg::RegEqLimit: prdata = 32'(cfg_q.enqueue_run_limit);
      sbtc_pkg::RegHold:    prdata = 32'(cfg_q.hold_ticks);
      sbtc_pkg::RegRelease: prdata = 32'(cfg_q.release_ticks);
      default:              prdata = 32'd0;
    endcase
  end

  sbtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  sbtc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
